@@ rtl/ttm_pkg.sv @@
// Shared constants and types of the track-to-terrain mapper.
`default_nettype none
package ttm_pkg;

  localparam int MAX_GRID_WIDTH_DEF = 256;
  localparam int MAX_GRID_DEPTH_DEF = 256;

  localparam int DEG_W       = 32;
  localparam int LEN_W       = 24;
  localparam int SCL_W       = 16;
  localparam int CNT_CFG_W   = 9;
  localparam int MARGIN_W    = 23;
  localparam int SPAN_W      = DEG_W + 1;
  localparam int CELL_AW     = 16;
  localparam int CFG_W       = 24;
  localparam int CFG_AW      = 3;
  localparam int KIND_W      = 2;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_WIDEN = 2'd1,
    KIND_MAP   = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  localparam logic [CFG_AW-1:0] REG_MAP_WIDTH  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MAP_HEIGHT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_HSCALE     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ESCALE     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ESHIFT     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_MARGIN     = 3'd5;

  localparam logic [CNT_CFG_W-1:0] MAP_WIDTH_RST  = 9'd256;
  localparam logic [CNT_CFG_W-1:0] MAP_HEIGHT_RST = 9'd256;
  localparam logic [SCL_W-1:0]     HSCALE_RST     = 16'd256;
  localparam logic [SCL_W-1:0]     ESCALE_RST     = 16'd256;
  localparam logic [LEN_W-1:0]     ESHIFT_RST     = 24'd0;
  localparam logic [MARGIN_W-1:0]  MARGIN_RST     = 23'd12800;

  localparam logic signed [DEG_W-1:0] DEG_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DEG_W-1:0] DEG_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

@@ rtl/ttm_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module ttm_div #(
  parameter int DW = 33,
  parameter int QW = 26
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DW+QW-1:0] dividend,
  input  wire logic [DW-1:0]    divisor,
  output logic                  busy,
  output logic                  done,
  output logic [QW-1:0]         quotient
);

  localparam int CNTW = $clog2(QW + 1);

  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   dvs_r;
  logic [QW-1:0]   q_r;
  logic [DW:0]     trial;
  logic            ge;
  logic [DW:0]     diff;

  assign trial = {rem_r, q_r[QW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DW+QW-1:QW];
      q_r   <= dividend[QW-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

@@ rtl/track_to_terrain_mapper.sv @@
// Top level of the track-to-terrain mapper.
// Kinds 0, 1 and 3 (cell write, box widen, box clear) are taken in the idle state
// and leave it idle. A mapped point (kind 2) holds in_tready low from its transfer
// until its result is registered on the output, where it waits while out_tready is low.
// Most of a mapped point's time is spent in the single serial divider, which runs the
// longitude and latitude normalizing divisions and the two cell-index
// divisions one bit per cycle. An axis with an empty box, or with a point at
// or beyond the box edge, skips its normalizing division. The height store is
// a synchronous RAM read once per point; a point reads its cell only after all
// earlier writes.
`default_nettype none
module track_to_terrain_mapper
  import ttm_pkg::*;
#(
  parameter int MAX_GRID_WIDTH = MAX_GRID_WIDTH_DEF,
  parameter int MAX_GRID_DEPTH = MAX_GRID_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // cell_index, cell_height, latitude, longitude, elevation
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  wire logic [KIND_W-1:0]      in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // x_pos, y_pos, z_pos
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_AW-1:0]      cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_wdata
);

  localparam int MAXC  = (MAX_GRID_WIDTH > MAX_GRID_DEPTH) ? MAX_GRID_WIDTH : MAX_GRID_DEPTH;
  localparam int CW    = $clog2(MAXC + 1);
  localparam int EXT_W = CW + SCL_W;
  localparam int PRW   = SPAN_W + EXT_W;
  localparam int PW    = (EXT_W + 2 > LEN_W + 1) ? EXT_W + 2 : LEN_W + 1;
  localparam int YM_W  = LEN_W + SCL_W + 1;
  localparam int YS_W  = YM_W - 8;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_AXIS, S_MLO, S_MHI, S_DSTART, S_DWAIT,
    S_CSTART, S_CWAIT, S_ADDR, S_RD
  } state_t;

  state_t state_r;

  logic [CNT_CFG_W-1:0] map_width_r, map_height_r;
  logic [SCL_W-1:0]     hscale_r, escale_r;
  logic [LEN_W-1:0]     eshift_r;
  logic [MARGIN_W-1:0]  margin_r;

  logic signed [DEG_W-1:0] lat_low_r, lat_high_r, lon_low_r, lon_high_r;

  logic signed [DEG_W-1:0] lat_r, lon_r;
  logic signed [LEN_W-1:0] elev_r;
  logic [EXT_W-1:0]        tw_r, td_r, offs_r;
  logic [SPAN_W-1:0]       num_r, span_r;
  logic [PRW-1:0]          prod_r;
  logic                    axis_r;
  logic [CW-1:0]           col_r, row_r;
  logic [LEN_W-1:0]        x_r, z_r, ysat_r;
  logic signed [YM_W-1:0]  ymul_r;
  logic [LEN_W-1:0]        rd_q;
  logic                    out_tvalid_r;
  logic [OUT_TDATA_W-1:0]  out_tdata_r;

  logic [LEN_W-1:0] hmem [0:(1<<CELL_AW)-1];

  logic              in_xfer;
  kind_t             in_kind;
  logic signed [DEG_W-1:0] in_lat, in_lon;
  logic [CW-1:0]     w_eff, d_eff, cnt_cur, cell_sel;
  logic [SCL_W-1:0]  s_eff;
  logic [EXT_W-1:0]  ext_cur, half_cur;
  logic signed [DEG_W-1:0] v_cur, lo_cur, hi_cur;
  logic signed [SPAN_W-1:0] span_c, t_c;
  logic              div_start, div_busy, div_done;
  logic [PRW-1:0]    div_dividend;
  logic [SPAN_W-1:0] div_divisor;
  logic [EXT_W-1:0]  div_q;
  logic signed [PW-1:0] pos;
  logic [LEN_W-1:0]  pos_sat;
  logic [CELL_AW-1:0] raddr;
  logic signed [YS_W-1:0]  ysh;
  logic signed [YS_W:0]    ydiff;
  logic signed [LEN_W:0]   h25, hm25, y25, yout;
  logic                    out_free;

  function automatic logic [LEN_W-1:0] sat_pos(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] mx, mn;
    mx = PW'(signed'({1'b0, {(LEN_W-1){1'b1}}}));
    mn = -mx - PW'(1);
    if (v > mx) return LEN_W'(mx);
    else if (v < mn) return LEN_W'(mn);
    else return LEN_W'(v);
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_kind   = kind_t'(in_tuser);
  assign in_lat    = in_tdata[71:40];
  assign in_lon    = in_tdata[103:72];
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    if (map_width_r == '0) w_eff = CW'(1);
    else if (32'(map_width_r) > MAX_GRID_WIDTH) w_eff = CW'(MAX_GRID_WIDTH);
    else w_eff = CW'(map_width_r);
    if (map_height_r == '0) d_eff = CW'(1);
    else if (32'(map_height_r) > MAX_GRID_DEPTH) d_eff = CW'(MAX_GRID_DEPTH);
    else d_eff = CW'(map_height_r);
    s_eff = (hscale_r == '0) ? SCL_W'(1) : hscale_r;
  end

  always_comb begin
    ext_cur  = axis_r ? td_r : tw_r;
    cnt_cur  = axis_r ? d_eff : w_eff;
    half_cur = ext_cur >> 1;
    v_cur    = axis_r ? lat_r : lon_r;
    lo_cur   = axis_r ? lat_low_r : lon_low_r;
    hi_cur   = axis_r ? lat_high_r : lon_high_r;
    span_c   = SPAN_W'(hi_cur) - SPAN_W'(lo_cur);
    t_c      = SPAN_W'(v_cur) - SPAN_W'(lo_cur);
  end

  always_comb begin
    div_start    = (state_r == S_DSTART) || (state_r == S_CSTART);
    div_dividend = (state_r == S_DSTART) ? prod_r : PRW'(offs_r);
    div_divisor  = (state_r == S_DSTART) ? span_r : SPAN_W'(s_eff);
  end

  ttm_div #(.DW(SPAN_W), .QW(EXT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    cell_sel = (div_q > EXT_W'(cnt_cur - 1'b1)) ? cnt_cur - 1'b1 : CW'(div_q);
    pos     = PW'(signed'({1'b0, offs_r})) - PW'(signed'({1'b0, half_cur}));
    pos_sat = sat_pos(pos);
    raddr   = CELL_AW'(row_r) * CELL_AW'(w_eff) + CELL_AW'(col_r);
    ysh     = YS_W'(ymul_r >>> 8);
    ydiff   = (YS_W+1)'(ysh) - (YS_W+1)'(signed'(eshift_r));
    h25     = (LEN_W+1)'(signed'(rd_q));
    hm25    = h25 + (LEN_W+1)'(margin_r);
    y25     = (LEN_W+1)'(signed'(ysat_r));
    if (y25 < h25) yout = h25;
    else if (y25 > hm25) yout = hm25;
    else yout = y25;
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_kind == KIND_WRITE) hmem[in_tdata[15:0]] <= in_tdata[39:16];
    if (state_r == S_ADDR) rd_q <= hmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= MAP_WIDTH_RST;
      map_height_r <= MAP_HEIGHT_RST;
      hscale_r     <= HSCALE_RST;
      escale_r     <= ESCALE_RST;
      eshift_r     <= ESHIFT_RST;
      margin_r     <= MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAP_WIDTH:  map_width_r  <= cfg_wdata[CNT_CFG_W-1:0];
        REG_MAP_HEIGHT: map_height_r <= cfg_wdata[CNT_CFG_W-1:0];
        REG_HSCALE:     hscale_r     <= cfg_wdata[SCL_W-1:0];
        REG_ESCALE:     escale_r     <= cfg_wdata[SCL_W-1:0];
        REG_ESHIFT:     eshift_r     <= cfg_wdata[LEN_W-1:0];
        REG_MARGIN:     margin_r     <= cfg_wdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      axis_r       <= 1'b0;
      lat_low_r    <= DEG_MAX;
      lat_high_r   <= DEG_MIN;
      lon_low_r    <= DEG_MAX;
      lon_high_r   <= DEG_MIN;
    end else begin
      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (in_kind)
              KIND_WIDEN: begin
                if (in_lat < lat_low_r)  lat_low_r  <= in_lat;
                if (in_lat > lat_high_r) lat_high_r <= in_lat;
                if (in_lon < lon_low_r)  lon_low_r  <= in_lon;
                if (in_lon > lon_high_r) lon_high_r <= in_lon;
              end
              KIND_CLEAR: begin
                lat_low_r  <= DEG_MAX;
                lat_high_r <= DEG_MIN;
                lon_low_r  <= DEG_MAX;
                lon_high_r <= DEG_MIN;
              end
              KIND_MAP: begin
                lat_r   <= in_lat;
                lon_r   <= in_lon;
                elev_r  <= in_tdata[127:104];
                axis_r  <= 1'b0;
                state_r <= S_PREP;
              end
              default: ;
            endcase
          end
        end
        S_PREP: begin
          tw_r    <= EXT_W'(w_eff) * EXT_W'(s_eff);
          td_r    <= EXT_W'(d_eff) * EXT_W'(s_eff);
          ymul_r  <= elev_r * YM_W'(signed'({1'b0, escale_r}));
          state_r <= S_AXIS;
        end
        S_AXIS: begin
          if (span_c <= 0 || t_c <= 0) begin
            offs_r  <= '0;
            state_r <= S_CSTART;
          end else if (t_c >= span_c) begin
            offs_r  <= {half_cur[EXT_W-2:0], 1'b0};
            state_r <= S_CSTART;
          end else begin
            num_r   <= t_c;
            span_r  <= span_c;
            state_r <= S_MLO;
          end
        end
        S_MLO: begin
          prod_r  <= PRW'(num_r[15:0]) * PRW'(ext_cur);
          state_r <= S_MHI;
        end
        S_MHI: begin
          prod_r  <= prod_r + ((PRW'(num_r[SPAN_W-1:16]) * PRW'(ext_cur)) << 16);
          state_r <= S_DSTART;
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            offs_r  <= div_q;
            state_r <= S_CSTART;
          end
        end
        S_CSTART: state_r <= S_CWAIT;
        S_CWAIT: begin
          if (div_done) begin
            if (!axis_r) begin
              col_r   <= cell_sel;
              x_r     <= pos_sat;
              axis_r  <= 1'b1;
              state_r <= S_AXIS;
            end else begin
              row_r   <= cell_sel;
              z_r     <= pos_sat;
              state_r <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          if (ydiff > (YS_W+1)'(signed'({1'b0, {(LEN_W-1){1'b1}}})))
            ysat_r <= {1'b0, {(LEN_W-1){1'b1}}};
          else if (ydiff < -(YS_W+1)'(signed'({1'b0, {(LEN_W-1){1'b1}}})) - 1)
            ysat_r <= {1'b1, {(LEN_W-1){1'b0}}};
          else
            ysat_r <= LEN_W'(ydiff);
          state_r <= S_RD;
        end
        S_RD: begin
          if (out_free) begin
            out_tdata_r  <= {z_r, LEN_W'(yout), x_r};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  a_rd_after_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> ($past(state_r) == S_ADDR || $past(state_r) == S_RD))
    else $error("height read without address cycle");
  a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADDR) |-> (col_r < w_eff && row_r < d_eff))
    else $error("cell index out of grid");
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");
`endif

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the track-to-terrain mapper: directed table, then random traffic.
`timescale 1ns / 1ps
module tb;
  import ttm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [KIND_W-1:0] in_tuser = KIND_WRITE;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = REG_MAP_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  track_to_terrain_mapper dut (.*);

  always #2 clk = ~clk;

  typedef struct packed {
    logic [LEN_W-1:0] x;
    logic [LEN_W-1:0] y;
    logic [LEN_W-1:0] z;
  } point_t;

  typedef struct {
    kind_t kind;
    logic [15:0] idx;
    logic [23:0] hgt;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [23:0] elev;
    bit chk;
    point_t want;
  } row_t;

  point_t pending_points[$];
  int errors = 0;

  // predictor state
  int cell_store[65536];
  bit cell_known[65536];
  longint lat_lo, lat_hi, lon_lo, lon_hi;
  longint grid_w, grid_d, hscale, escale, eshift, margin;

  int burst_left = 0;
  int stall_phase = 0;

  task automatic report(string what, logic [23:0] got, logic [23:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint map_axis(longint v, longint lo, longint hi, longint ext);
    longint half, span;
    half = ext / 2;
    span = hi - lo;
    if (span <= 0) return -half;
    return clampl(fdiv((v - lo) * ext, span) - half, -half, half);
  endfunction

  function automatic void reset_box();
    lat_lo = 64'sd2147483647;
    lat_hi = -64'sd2147483648;
    lon_lo = 64'sd2147483647;
    lon_hi = -64'sd2147483648;
  endfunction

  // cell address and world point of a mapped track point
  function automatic int locate_point(logic [31:0] lat, logic [31:0] lon, logic [23:0] elev,
                                      output point_t p);
    longint w, d, s, tw, td, x, z, y, col, row, h;
    int addr;
    w = (grid_w == 0) ? 1 : (grid_w > 256 ? 256 : grid_w);
    d = (grid_d == 0) ? 1 : (grid_d > 256 ? 256 : grid_d);
    s = (hscale == 0) ? 1 : hscale;
    tw = w * s;
    td = d * s;
    x = map_axis(longint'($signed(lon)), lon_lo, lon_hi, tw);
    z = map_axis(longint'($signed(lat)), lat_lo, lat_hi, td);
    col = clampl((x + tw / 2) / s, 0, w - 1);
    row = clampl((z + td / 2) / s, 0, d - 1);
    addr = int'((row * w + col) & 64'hFFFF);
    h = cell_store[addr];
    y = fdiv(longint'($signed(elev)) * escale, 256) - eshift;
    y = clampl(y, -8388608, 8388607);
    y = clampl(y, h, h + margin);
    p.x = 24'(clampl(x, -8388608, 8388607));
    p.y = 24'(y);
    p.z = 24'(clampl(z, -8388608, 8388607));
    return addr;
  endfunction

  task automatic drive_raw(kind_t kind, logic [15:0] idx, logic [23:0] hgt,
                           logic [31:0] lat, logic [31:0] lon, logic [23:0] elev);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = {elev, lon, lat, hgt, idx};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send(kind_t kind, logic [15:0] idx, logic [23:0] hgt, logic [31:0] lat,
                      logic [31:0] lon, logic [23:0] elev, bit chk = 0, point_t want = '0);
    point_t p;
    int addr;
    logic [23:0] fill;
    case (kind)
      KIND_WRITE: begin
        cell_store[idx] = int'($signed(hgt));
        cell_known[idx] = 1'b1;
      end
      KIND_WIDEN: begin
        if ($signed(lat) < lat_lo) lat_lo = $signed(lat);
        if ($signed(lat) > lat_hi) lat_hi = $signed(lat);
        if ($signed(lon) < lon_lo) lon_lo = $signed(lon);
        if ($signed(lon) > lon_hi) lon_hi = $signed(lon);
      end
      KIND_CLEAR: reset_box();
      default: begin
        addr = locate_point(lat, lon, elev, p);
        if (!cell_known[addr]) begin
          // never read a cell that holds nothing
          fill = 24'($urandom);
          if ($urandom_range(0, 1)) fill = 24'($signed(fill) >>> 8);
          cell_store[addr] = int'($signed(fill));
          cell_known[addr] = 1'b1;
          drive_raw(KIND_WRITE, 16'(addr), fill, 32'($urandom), 32'($urandom), 24'($urandom));
          addr = locate_point(lat, lon, elev, p);
        end
        pending_points.push_back(chk ? want : p);
      end
    endcase
    drive_raw(kind, idx, hgt, lat, lon, elev);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] r, logic [CFG_W-1:0] v);
    cfg_we = 1'b1;
    cfg_addr = r;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (r)
      REG_MAP_WIDTH:  grid_w = v[8:0];
      REG_MAP_HEIGHT: grid_d = v[8:0];
      REG_HSCALE:     hscale = v[15:0];
      REG_ESCALE:     escale = v[15:0];
      REG_ESHIFT:     eshift = longint'($signed(v[23:0]));
      default:        margin = v[22:0];
    endcase
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_deg(logic [31:0] center, int spread);
    return center + 32'($signed(32'($urandom)) >>> spread);
  endfunction

  task automatic random_items(int n);
    logic [31:0] clat, clon, lat, lon;
    int spread, pick;
    clat = $urandom;
    clon = $urandom;
    spread = $urandom_range(0, 31);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      lat = rand_deg(clat, spread);
      lon = rand_deg(clon, spread);
      if (pick < 3) begin
        send(KIND_CLEAR, 16'($urandom), 24'($urandom), 32'($urandom), 32'($urandom),
             24'($urandom));
        clat = $urandom;
        clon = $urandom;
        spread = $urandom_range(0, 31);
      end else if (pick < 25) begin
        send(KIND_WIDEN, 16'($urandom), 24'($urandom), lat, lon, 24'($urandom));
      end else if (pick < 35) begin
        send(KIND_WRITE, 16'($urandom), 24'($urandom), lat, lon, 24'($urandom));
      end else if (pick < 40) begin
        send(KIND_MAP, 16'($urandom), 24'($urandom), 32'($urandom), 32'($urandom),
             24'($urandom));
      end else begin
        send(KIND_MAP, 16'($urandom), 24'($urandom), lat, lon, 24'($urandom));
      end
    end
  endtask

  row_t plan[] = '{
    '{KIND_WRITE, 16'h0000, 24'h000000, 32'h0, 32'h0, 24'h0, 1'b0, '0},
    '{KIND_MAP,   16'h0000, 24'h000000, 32'h0, 32'h0, 24'h000000, 1'b1,
      '{24'hFF8000, 24'h000000, 24'hFF8000}},
    '{KIND_MAP,   16'h0000, 24'h000000, 32'h0, 32'h0, 24'h006400, 1'b1,
      '{24'hFF8000, 24'h003200, 24'hFF8000}},
    '{KIND_MAP,   16'hFFFF, 24'hFFFFFF, 32'h0, 32'h0, 24'h800000, 1'b1,
      '{24'hFF8000, 24'h000000, 24'hFF8000}},
    '{KIND_WRITE, 16'hFFFF, 24'h7FFFFF, 32'h0, 32'h0, 24'h0, 1'b0, '0},
    '{KIND_WIDEN, 16'h0000, 24'h000000, DEG_MIN, DEG_MIN, 24'h0, 1'b0, '0},
    '{KIND_WIDEN, 16'h0000, 24'h000000, DEG_MAX, DEG_MAX, 24'h0, 1'b0, '0},
    '{KIND_MAP,   16'h0000, 24'h000000, DEG_MAX, DEG_MAX, 24'h7FFFFF, 1'b1,
      '{24'h008000, 24'h7FFFFF, 24'h008000}},
    '{KIND_MAP,   16'h0000, 24'h000000, DEG_MIN, DEG_MIN, 24'h000000, 1'b1,
      '{24'hFF8000, 24'h000000, 24'hFF8000}},
    '{KIND_MAP,   16'h0000, 24'h000000, 32'h0, 32'h0, 24'h123456, 1'b0, '0},
    '{KIND_MAP,   16'h0000, 24'h000000, 32'h12345678, 32'hEDCBA987, 24'h800000, 1'b0, '0},
    '{KIND_WRITE, 16'h1234, 24'h800000, 32'h0, 32'h0, 24'h0, 1'b0, '0},
    '{KIND_CLEAR, 16'h0000, 24'h000000, 32'h0, 32'h0, 24'h0, 1'b0, '0},
    '{KIND_MAP,   16'h0000, 24'h000000, 32'h7FFFFFFF, 32'h0, 24'h000000, 1'b1,
      '{24'hFF8000, 24'h000000, 24'hFF8000}}
  };

  // receiver stall pattern
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase / 97) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ((stall_phase % 5) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_points.size() == 0) begin
        report("unexpected transfer", out_tdata[23:0], 24'h000000);
      end else begin
        point_t want;
        want = pending_points.pop_front();
        if (out_tdata[23:0] !== want.x) report("x_pos", out_tdata[23:0], want.x);
        if (out_tdata[47:24] !== want.y) report("y_pos", out_tdata[47:24], want.y);
        if (out_tdata[71:48] !== want.z) report("z_pos", out_tdata[71:48], want.z);
      end
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    reset_box();
    grid_w = 256; grid_d = 256; hscale = 256; escale = 256; eshift = 0; margin = 12800;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i])
      send(plan[i].kind, plan[i].idx, plan[i].hgt, plan[i].lat, plan[i].lon, plan[i].elev,
           plan[i].chk, plan[i].want);
    random_items(200);

    for (int ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_MAP_WIDTH, 24'd1); write_reg(REG_MAP_HEIGHT, 24'd1);
          write_reg(REG_HSCALE, 24'd0); write_reg(REG_ESCALE, 24'd0);
          write_reg(REG_ESHIFT, 24'h800000); write_reg(REG_MARGIN, 24'h7FFFFF);
        end
        1: begin
          write_reg(REG_MAP_WIDTH, 24'd0); write_reg(REG_MAP_HEIGHT, 24'd511);
          write_reg(REG_HSCALE, 24'd65535); write_reg(REG_ESCALE, 24'd65535);
          write_reg(REG_ESHIFT, 24'h7FFFFF); write_reg(REG_MARGIN, 24'd0);
        end
        2: begin
          write_reg(REG_MAP_WIDTH, 24'd256); write_reg(REG_MAP_HEIGHT, 24'd256);
          write_reg(REG_HSCALE, 24'd65535); write_reg(REG_ESCALE, 24'd1);
          write_reg(REG_ESHIFT, 24'd0); write_reg(REG_MARGIN, 24'd12800);
        end
        default: begin
          write_reg(REG_MAP_WIDTH, 24'($urandom_range(0, 511)));
          write_reg(REG_MAP_HEIGHT, 24'($urandom_range(0, 511)));
          write_reg(REG_HSCALE, 24'($urandom_range(0, 2) == 0 ? $urandom_range(0, 65535)
                                                             : $urandom_range(1, 1024)));
          write_reg(REG_ESCALE, 24'($urandom_range(0, 65535)));
          write_reg(REG_ESHIFT, 24'($urandom));
          write_reg(REG_MARGIN, 24'($urandom_range(0, 8388607) >> $urandom_range(0, 16)));
        end
      endcase
      random_items(200);
    end

    settle();
    repeat (200) @(negedge clk);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ttm_pkg.sv
rtl/ttm_div.sv
rtl/track_to_terrain_mapper.sv
bench/tb.sv
